### hdl/cleb_pkg.sv
// ---------------------------------------------------------------------------
// cleb_pkg: shared types and constants of the line edit buffer
// Key operation codes, the command word passed from front to back, and
// configuration register indexes with their reset key codes.
// ---------------------------------------------------------------------------
`default_nettype none

package cleb_pkg;

    localparam int KEY_W   = 8;
    localparam int CFG_IW  = 2;
    localparam int Q_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_LEFT_KEY  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_RIGHT_KEY = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_ERASE_KEY = 2'd2;

    // key codes after reset: '<', '>', '-'
    localparam logic [KEY_W-1:0] RST_LEFT_KEY  = 8'd60;
    localparam logic [KEY_W-1:0] RST_RIGHT_KEY = 8'd62;
    localparam logic [KEY_W-1:0] RST_ERASE_KEY = 8'd45;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LEFT   = 2'd1,
        OP_RIGHT  = 2'd2,
        OP_ERASE  = 2'd3
    } t_op;

    // one classified key on its way to the executor
    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
        logic             eol;
    } t_cmd;

    // queue head as seen by the executor
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage

`default_nettype wire

### hdl/cleb_front.sv
// ---------------------------------------------------------------------------
// cleb_front: key intake and classification
// Holds the key code registers, decodes each accepted key into an
// operation and pushes it into the command queue.
// ---------------------------------------------------------------------------
`default_nettype none

module cleb_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [cleb_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  wire logic [cleb_pkg::KEY_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [cleb_pkg::KEY_W-1:0]    i_key_byte,
    input  wire logic                          i_line_end,
    input  wire logic                          i_q_full,
    output logic                               o_push,
    output cleb_pkg::t_cmd                     o_cmd
);

    logic [cleb_pkg::KEY_W-1:0] r_left_key;
    logic [cleb_pkg::KEY_W-1:0] r_right_key;
    logic [cleb_pkg::KEY_W-1:0] r_erase_key;

    // key code registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_key  <= cleb_pkg::RST_LEFT_KEY;
            r_right_key <= cleb_pkg::RST_RIGHT_KEY;
            r_erase_key <= cleb_pkg::RST_ERASE_KEY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cleb_pkg::CFG_LEFT_KEY:  r_left_key  <= i_cfg_data;
                cleb_pkg::CFG_RIGHT_KEY: r_right_key <= i_cfg_data;
                cleb_pkg::CFG_ERASE_KEY: r_erase_key <= i_cfg_data;
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // classify: first matching code wins
    always_comb begin
        o_cmd.key = i_key_byte;
        o_cmd.eol = i_line_end;
        priority if (i_key_byte == r_left_key) begin
            o_cmd.op = cleb_pkg::OP_LEFT;
        end else if (i_key_byte == r_right_key) begin
            o_cmd.op = cleb_pkg::OP_RIGHT;
        end else if (i_key_byte == r_erase_key) begin
            o_cmd.op = cleb_pkg::OP_ERASE;
        end else begin
            o_cmd.op = cleb_pkg::OP_INSERT;
        end
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

endmodule

`default_nettype wire

### hdl/cleb_queue.sv
// ---------------------------------------------------------------------------
// cleb_queue: command queue between intake and executor
// Small FIFO of classified keys; lets intake and executor stall apart.
// ---------------------------------------------------------------------------
`default_nettype none

module cleb_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire cleb_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output cleb_pkg::t_q_head   o_head
);

    localparam int PW = $clog2(cleb_pkg::Q_DEPTH);
    localparam int CW = $clog2(cleb_pkg::Q_DEPTH + 1);

    cleb_pkg::t_cmd r_entry [cleb_pkg::Q_DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_count;
    logic           do_pop;

    assign o_full      = (r_count == CW'(cleb_pkg::Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_entry[r_rptr];
    assign do_pop       = i_pop && o_head.valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(cleb_pkg::Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(cleb_pkg::Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/cleb_back.sv
// ---------------------------------------------------------------------------
// cleb_back: gap buffer executor and line readout
// Applies queued key operations to the text memory (left part grows up
// from 0, right part down from the top) and, on line end, streams the
// line out through an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module cleb_back #(
    parameter int CAPACITY = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire cleb_pkg::t_q_head           i_head,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [cleb_pkg::KEY_W-1:0]       o_text_byte,
    output logic                             o_final_char,
    output logic                             o_line_empty,
    output logic                             o_overflowed
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MOVE = 5'b00010,
        S_LINE = 5'b00100,
        S_RD   = 5'b01000,
        S_RDW  = 5'b10000
    } t_state;

    t_state                     r_state, n_state;
    logic [CW-1:0]              r_left, n_left;
    logic [CW-1:0]              r_right, n_right;
    logic                       r_ovf, n_ovf;
    logic                       r_eol, n_eol;
    logic                       r_dir_left, n_dir_left;
    logic [CW-1:0]              r_k, n_k;
    logic                       r_out_valid, n_out_valid;
    logic [cleb_pkg::KEY_W-1:0] r_out_byte;
    logic                       r_out_final;
    logic                       r_out_empty;
    logic                       r_out_ovf;

    logic [cleb_pkg::KEY_W-1:0] r_text_mem [CAPACITY];
    logic [cleb_pkg::KEY_W-1:0] r_rd_data;

    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [cleb_pkg::KEY_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [AW-1:0]              mem_raddr;

    logic                       out_load;
    logic [cleb_pkg::KEY_W-1:0] out_byte;
    logic                       out_final;
    logic                       out_empty;

    logic [CW-1:0]              total;
    logic                       slot_free;
    logic                       is_last;
    logic [CW-1:0]              rd_pos;
    logic [CW-1:0]              top_wr;

    assign total     = r_left + r_right;
    assign slot_free = !r_out_valid || !i_out_stall;
    assign is_last   = ((r_k + 1'b1) == total);
    // readout position k maps into the left part, then the right part
    assign rd_pos    = (r_k < r_left) ? r_k : (CAP - total + r_k);
    assign top_wr    = CAP - 1'b1 - r_right;

    // text memory: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_text_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_text_mem[mem_raddr];
        end
    end

    // executor control
    always_comb begin
        n_state     = r_state;
        n_left      = r_left;
        n_right     = r_right;
        n_ovf       = r_ovf;
        n_eol       = r_eol;
        n_dir_left  = r_dir_left;
        n_k         = r_k;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_left[AW-1:0];
        mem_wdata   = i_head.cmd.key;
        mem_re      = 1'b0;
        mem_raddr   = rd_pos[AW-1:0];
        out_load    = 1'b0;
        out_byte    = r_rd_data;
        out_final   = is_last;
        out_empty   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop      = 1'b1;
                    n_eol      = i_head.cmd.eol;
                    n_dir_left = (i_head.cmd.op == cleb_pkg::OP_LEFT);
                    n_state    = i_head.cmd.eol ? S_LINE : S_IDLE;
                    unique case (i_head.cmd.op)
                        cleb_pkg::OP_LEFT: begin
                            if (r_left != '0) begin
                                mem_re    = 1'b1;
                                mem_raddr = AW'(r_left - 1'b1);
                                n_state   = S_MOVE;
                            end
                        end
                        cleb_pkg::OP_RIGHT: begin
                            if (r_right != '0) begin
                                mem_re    = 1'b1;
                                mem_raddr = AW'(CAP - r_right);
                                n_state   = S_MOVE;
                            end
                        end
                        cleb_pkg::OP_ERASE: begin
                            if (r_left != '0) begin
                                n_left = r_left - 1'b1;
                            end
                        end
                        cleb_pkg::OP_INSERT: begin
                            if (total < CAP) begin
                                mem_we = 1'b1;
                                n_left = r_left + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // second half of a cursor move: write the carried character
            S_MOVE: begin
                mem_we    = 1'b1;
                mem_wdata = r_rd_data;
                if (r_dir_left) begin
                    mem_waddr = top_wr[AW-1:0];
                    n_left    = r_left - 1'b1;
                    n_right   = r_right + 1'b1;
                end else begin
                    mem_waddr = r_left[AW-1:0];
                    n_left    = r_left + 1'b1;
                    n_right   = r_right - 1'b1;
                end
                n_state = r_eol ? S_LINE : S_IDLE;
            end

            // start of readout; empty line gives a single flagged item
            S_LINE: begin
                if (total == '0) begin
                    if (slot_free) begin
                        out_load  = 1'b1;
                        out_byte  = '0;
                        out_final = 1'b1;
                        out_empty = 1'b1;
                        n_ovf     = 1'b0;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_k     = '0;
                    n_state = S_RD;
                end
            end

            S_RD: begin
                mem_re  = 1'b1;
                n_state = S_RDW;
            end

            // read data held until the output slot frees up
            S_RDW: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    if (is_last) begin
                        n_left  = '0;
                        n_right = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_RD;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // output register valid
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte  <= out_byte;
            r_out_final <= out_final;
            r_out_empty <= out_empty;
            r_out_ovf   <= r_ovf;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_left      <= '0;
            r_right     <= '0;
            r_ovf       <= 1'b0;
            r_eol       <= 1'b0;
            r_dir_left  <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_right     <= n_right;
            r_ovf       <= n_ovf;
            r_eol       <= n_eol;
            r_dir_left  <= n_dir_left;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_text_byte  = r_out_byte;
    assign o_final_char = r_out_final;
    assign o_line_empty = r_out_empty;
    assign o_overflowed = r_out_ovf;

endmodule

`default_nettype wire

### hdl/cursor_line_edit_buffer.sv
// ---------------------------------------------------------------------------
// cursor_line_edit_buffer: line editor over a key stream (gap buffer)
// Keys come in on the input channel (i_in_valid / o_in_stall with
// i_key_byte, i_line_end). Left, right and erase codes are set through the
// write port (i_cfg_we, i_cfg_idx, i_cfg_data); any other byte is inserted.
// On a key flagged line end the key is applied, then the line goes out on
// the output channel (o_out_valid / i_out_stall), one item per character,
// the last one flagged; an empty line gives one item flagged empty.
// A key is written into the command queue when it is accepted and is
// executed once it is at the queue head and the executor is idle. Insert
// and erase are applied in the idle state; a cursor move is a registered
// read, then a write of the text memory. Readout starts in S_LINE; each
// character is then read (S_RD, S_RDW). A two-entry command queue keeps
// intake going while the executor is busy. If the receiver stalls, the
// output register keeps its item, readout pauses; a full queue stalls intake.
// Reset (synchronous, active low) empties the line, clears the overflow
// flag and restores the key codes to '<', '>' and '-'. No clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module cursor_line_edit_buffer #(
    parameter int CAPACITY = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [cleb_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  wire logic [cleb_pkg::KEY_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [cleb_pkg::KEY_W-1:0]    i_key_byte,
    input  wire logic                          i_line_end,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [cleb_pkg::KEY_W-1:0]         o_text_byte,
    output logic                               o_final_char,
    output logic                               o_line_empty,
    output logic                               o_overflowed
);

    logic               q_full;
    logic               q_push;
    logic               q_pop;
    cleb_pkg::t_cmd     q_cmd;
    cleb_pkg::t_q_head  q_head;

    cleb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_key_byte (i_key_byte),
        .i_line_end (i_line_end),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (q_cmd)
    );

    cleb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    cleb_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_text_byte  (o_text_byte),
        .o_final_char (o_final_char),
        .o_line_empty (o_line_empty),
        .o_overflowed (o_overflowed)
    );

endmodule

`default_nettype wire
